// ----- rtl/projected_pixel_depth_blend_assert.svh -----
// Assertion macros for the pixel depth blend block.
// Expects clk and rst in the scope of the including module.
`ifndef PROJECTED_PIXEL_DEPTH_BLEND_ASSERT_SVH
`define PROJECTED_PIXEL_DEPTH_BLEND_ASSERT_SVH

// same-cycle implication
`define PPDB_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPDB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ppdb_pkg.sv -----
// Shared constants and types for the pixel depth blend block.
// No dependencies.
`default_nettype none

package ppdb_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  // quotient bits kept exact; anything larger is off the surface
  localparam int QBITS      = $clog2(MAX_DIM) + 1;

  localparam int POS_W   = 24;
  localparam int FOV_W   = 16;
  localparam int MAG_W   = POS_W + FOV_W;
  localparam int DEN_W   = 32;
  localparam int DSH_W   = DEN_W + QBITS;
  localparam int REM_W   = (MAG_W > DSH_W) ? MAG_W : DSH_W;

  localparam int DEPTH_W  = 24;
  localparam int COLOUR_W = 24;
  localparam logic [DEPTH_W-1:0] FAR_DEPTH = '1;

  typedef enum logic {
    FN_PLOT  = 1'b0,
    FN_CLEAR = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_WRITTEN = 3'd0,
    ST_NEAR    = 3'd1,
    ST_OFF     = 3'd2,
    ST_DEPTH   = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_WIDTH      = 3'd0,
    REG_HEIGHT     = 3'd1,
    REG_FOV        = 3'd2,
    REG_NEAR       = 3'd3,
    REG_DEPTH_TEST = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic             done;
    logic             big;
    logic             rem_nz;
    logic [QBITS-1:0] quo;
  } div_res_t;

  typedef struct packed {
    logic                col_en;
    logic                dep_en;
    logic [ADDR_W-1:0]   addr;
    logic [COLOUR_W-1:0] colour;
    logic [DEPTH_W-1:0]  depth;
  } store_wr_t;

endpackage

`default_nettype wire

// ----- rtl/ppdb_div.sv -----
// Shared multiply then restoring divide unit, one quotient bit per cycle.
// Depends on ppdb_pkg.
`default_nettype none

module ppdb_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [ppdb_pkg::POS_W-1:0]  magnitude,
  input  wire logic [ppdb_pkg::FOV_W-1:0]  scale,
  input  wire logic [ppdb_pkg::DEN_W-1:0]  divisor,
  output ppdb_pkg::div_res_t               res
);

  localparam int CNT_W = $clog2(ppdb_pkg::QBITS + 1);

  logic                           busy;
  logic                           done;
  logic [CNT_W-1:0]               cnt;
  logic [ppdb_pkg::REM_W-1:0]     rem;
  logic [ppdb_pkg::DSH_W-1:0]     dsh;
  logic [ppdb_pkg::QBITS-1:0]     quo;
  logic                           big;
  logic [ppdb_pkg::MAG_W-1:0]     prod;
  logic [ppdb_pkg::REM_W-1:0]     dsh_ext;
  logic                           ge;

  assign prod    = {{ppdb_pkg::FOV_W{1'b0}}, magnitude} * {{ppdb_pkg::POS_W{1'b0}}, scale};
  assign dsh_ext = ppdb_pkg::REM_W'(dsh);
  assign ge      = (rem >= dsh_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= ppdb_pkg::REM_W'(prod);
        dsh  <= {divisor, {ppdb_pkg::QBITS{1'b0}}};
        quo  <= '0;
        big  <= 1'b0;
      end else if (busy) begin
        if (cnt == '0) begin
          big <= ge;
        end else begin
          if (ge) begin
            rem <= rem - dsh_ext;
          end
          quo <= {quo[ppdb_pkg::QBITS-2:0], ge};
        end
        dsh <= dsh >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ppdb_pkg::QBITS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    res.done   = done;
    res.big    = big;
    res.rem_nz = |rem;
    res.quo    = quo;
  end

endmodule

`default_nettype wire

// ----- rtl/ppdb_store.sv -----
// Colour and depth stores, one write and one registered read port each,
// with a clearing sweep after reset. Depends on ppdb_pkg.
`default_nettype none

module ppdb_store (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ppdb_pkg::store_wr_t           wr,
  input  wire logic [ppdb_pkg::ADDR_W-1:0]   rd_addr,
  output logic      [ppdb_pkg::COLOUR_W-1:0] colour_rd,
  output logic      [ppdb_pkg::DEPTH_W-1:0]  depth_rd,
  output logic                               busy
);

  logic [ppdb_pkg::COLOUR_W-1:0] colour_mem [ppdb_pkg::STORE_SIZE];
  logic [ppdb_pkg::DEPTH_W-1:0]  depth_mem  [ppdb_pkg::STORE_SIZE];

  logic [ppdb_pkg::ADDR_W-1:0]   sweep_addr;
  logic                          c_we;
  logic                          d_we;
  logic [ppdb_pkg::ADDR_W-1:0]   w_addr;
  logic [ppdb_pkg::COLOUR_W-1:0] c_data;
  logic [ppdb_pkg::DEPTH_W-1:0]  d_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      sweep_addr <= '0;
    end else if (busy) begin
      sweep_addr <= sweep_addr + 1'b1;
      if (sweep_addr == ppdb_pkg::ADDR_W'(ppdb_pkg::STORE_SIZE - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    c_we   = busy | wr.col_en;
    d_we   = busy | wr.dep_en;
    w_addr = busy ? sweep_addr : wr.addr;
    c_data = busy ? '0 : wr.colour;
    d_data = busy ? ppdb_pkg::FAR_DEPTH : wr.depth;
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      colour_mem[w_addr] <= c_data;
    end
    colour_rd <= colour_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      depth_mem[w_addr] <= d_data;
    end
    depth_rd <= depth_mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/projected_pixel_depth_blend.sv -----
// Pixel write unit: projection, depth test and alpha blend into a 64x64 store.
// Depends on ppdb_pkg, ppdb_div, ppdb_store and the assertion header.
//
// A plot word makes two passes through the shared multiply/divide unit, one
// for x and one for y, then projection, address, store read, depth test, a
// per-channel blend of red, green and blue and the write. A too-near plot
// and a clear word skip the divider. No new word is taken while one is in
// flight, but the result sits in an output register, so a new word is taken
// while the previous result waits. After reset the store is swept to black
// and far depth over all STORE_SIZE (4096) entries with in_ready low.
// cfg_ready is always high; write registers only while no word is in flight.
`default_nettype none
`include "projected_pixel_depth_blend_assert.svh"

module projected_pixel_depth_blend (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               func,
  input  wire logic signed [23:0] pos_x,
  input  wire logic signed [23:0] pos_y,
  input  wire logic        [23:0] depth_z,
  input  wire logic        [7:0]  red,
  input  wire logic        [7:0]  green,
  input  wire logic        [7:0]  blue,
  input  wire logic        [7:0]  alpha,
  input  wire logic        [11:0] clear_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic             [2:0]  status,
  output logic             [11:0] pixel_index,
  output logic             [7:0]  out_red,
  output logic             [7:0]  out_green,
  output logic             [7:0]  out_blue,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [15:0] cfg_data
);

  localparam int DIM_W = 7;
  localparam int QB    = ppdb_pkg::QBITS;
  localparam int CW    = ((QB > DIM_W) ? QB : DIM_W) + 2;
  localparam int IDX_W = (CW - 1) + DIM_W + 1;
  localparam logic [7:0] ALPHA_ONE = 8'd255;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_XSTART,
    S_XWAIT,
    S_YSTART,
    S_YWAIT,
    S_PROJ,
    S_ADDR,
    S_READ,
    S_TEST,
    S_BLEND,
    S_WRITE,
    S_DONE
  } state_t;

  // configuration
  logic [DIM_W-1:0] surface_width;
  logic [DIM_W-1:0] surface_height;
  logic [15:0]      field_of_view;
  logic [15:0]      near_depth;
  logic             depth_test_on;

  state_t            state;
  chan_t             chan;
  ppdb_pkg::status_t res_status;
  logic [11:0]       res_index;

  logic [ppdb_pkg::POS_W-1:0]   x_mag;
  logic [ppdb_pkg::POS_W-1:0]   y_mag;
  logic                         x_neg;
  logic                         y_neg;
  logic [ppdb_pkg::DEPTH_W-1:0] z_q;
  logic [7:0]                   r_q;
  logic [7:0]                   g_q;
  logic [7:0]                   b_q;
  logic [7:0]                   a_q;
  logic [11:0]                  ci_q;

  logic [QB-1:0] qx;
  logic [QB-1:0] qy;
  logic          bigx;
  logic          bigy;
  logic          nzx;
  logic          nzy;
  logic [CW-2:0] sx_u;
  logic [CW-2:0] sy_u;
  logic [ppdb_pkg::ADDR_W-1:0] addr;
  logic [7:0]    nr;
  logic [7:0]    ng;
  logic [7:0]    nb;

  logic [DIM_W-1:0]     w_sat;
  logic [DIM_W-1:0]     h_sat;
  logic signed [CW-1:0] sx_c;
  logic signed [CW-1:0] sy_c;
  logic                 off_c;
  logic [IDX_W-1:0]     idx_full;
  logic                 clr_ok;
  logic [7:0]           c_sel;
  logic [7:0]           b_sel;
  logic [7:0]           blend_c;

  logic                            div_start;
  logic [ppdb_pkg::POS_W-1:0]      div_mag;
  ppdb_pkg::div_res_t              div_res;
  ppdb_pkg::store_wr_t             st_wr;
  logic [ppdb_pkg::COLOUR_W-1:0]   colour_rd;
  logic [ppdb_pkg::DEPTH_W-1:0]    depth_rd;
  logic                            store_busy;

  logic out_unwritten;
  logic out_rgb_zero;
  logic out_rejected;
  logic div_waiting;
  logic dep_allowed;

  // trunc(half +/- q) toward zero, q with remainder flag
  function automatic logic signed [CW-1:0] proj(input logic [DIM_W-1:0] half,
                                                input logic [QB-1:0] q,
                                                input logic neg,
                                                input logic nz);
    logic signed [CW-1:0] h_s;
    logic signed [CW-1:0] q_s;
    logic signed [CW-1:0] t;
    h_s = $signed(CW'(half));
    q_s = $signed(CW'(q));
    if (!neg) begin
      t = h_s + q_s;
    end else begin
      t = h_s - q_s;
      if (nz && !t[CW-1] && (t != '0)) begin
        t = t - 1'b1;
      end
    end
    return t;
  endfunction

  // (c*a + b*(255-a)) div 255
  function automatic logic [7:0] blend(input logic [7:0] c, input logic [7:0] b,
                                       input logic [7:0] a);
    logic [15:0] v;
    logic [16:0] s;
    v = 16'(c) * 16'(a) + 16'(b) * 16'(ALPHA_ONE - a);
    s = 17'(v) + 17'(v >> 8) + 17'd1;
    return s[15:8];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && !store_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= 7'd64;
      surface_height <= 7'd64;
      field_of_view  <= 16'd256;
      near_depth     <= 16'd26;
      depth_test_on  <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ppdb_pkg::REG_WIDTH:      surface_width  <= cfg_data[DIM_W-1:0];
        ppdb_pkg::REG_HEIGHT:     surface_height <= cfg_data[DIM_W-1:0];
        ppdb_pkg::REG_FOV:        field_of_view  <= cfg_data;
        ppdb_pkg::REG_NEAR:       near_depth     <= cfg_data;
        ppdb_pkg::REG_DEPTH_TEST: depth_test_on  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_sat = (32'(surface_width) > ppdb_pkg::MAX_WIDTH) ?
            DIM_W'(ppdb_pkg::MAX_WIDTH) : surface_width;
    h_sat = (32'(surface_height) > ppdb_pkg::MAX_HEIGHT) ?
            DIM_W'(ppdb_pkg::MAX_HEIGHT) : surface_height;
    sx_c  = proj(w_sat >> 1, qx, x_neg, nzx);
    sy_c  = proj(h_sat >> 1, qy, y_neg, nzy);
    off_c = bigx || bigy || sx_c[CW-1] || sy_c[CW-1] ||
            ($unsigned(sx_c) >= CW'(w_sat)) || ($unsigned(sy_c) >= CW'(h_sat));
    idx_full = IDX_W'(sy_u) * IDX_W'(w_sat) + IDX_W'(sx_u);
    clr_ok   = 32'(ci_q) < ppdb_pkg::STORE_SIZE;
  end

  always_comb begin
    unique case (chan)
      CH_RED: begin
        c_sel = r_q;
        b_sel = colour_rd[23:16];
      end
      CH_GREEN: begin
        c_sel = g_q;
        b_sel = colour_rd[15:8];
      end
      CH_BLUE: begin
        c_sel = b_q;
        b_sel = colour_rd[7:0];
      end
      default: begin
        c_sel = '0;
        b_sel = '0;
      end
    endcase
    blend_c = blend(c_sel, b_sel, a_q);
  end

  assign div_start = (state == S_XSTART) || (state == S_YSTART);
  assign div_mag   = (state == S_XSTART) ? x_mag : y_mag;

  ppdb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .magnitude (div_mag),
    .scale     (field_of_view),
    .divisor   ({z_q, 8'd0}),
    .res       (div_res)
  );

  always_comb begin
    st_wr.col_en = (state == S_WRITE) || ((state == S_CLEAR) && clr_ok);
    st_wr.dep_en = ((state == S_WRITE) && depth_test_on) || ((state == S_CLEAR) && clr_ok);
    st_wr.addr   = (state == S_CLEAR) ? ppdb_pkg::ADDR_W'(ci_q) : addr;
    st_wr.colour = (state == S_CLEAR) ? '0 : {nr, ng, nb};
    st_wr.depth  = (state == S_CLEAR) ? ppdb_pkg::FAR_DEPTH : z_q;
  end

  ppdb_store u_store (
    .clk       (clk),
    .rst       (rst),
    .wr        (st_wr),
    .rd_addr   (addr),
    .colour_rd (colour_rd),
    .depth_rd  (depth_rd),
    .busy      (store_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            x_mag <= pos_x[23] ? ppdb_pkg::POS_W'(-pos_x) : ppdb_pkg::POS_W'(pos_x);
            y_mag <= pos_y[23] ? ppdb_pkg::POS_W'(-pos_y) : ppdb_pkg::POS_W'(pos_y);
            x_neg <= pos_x[23];
            y_neg <= !pos_y[23] && (pos_y != '0);
            z_q   <= depth_z;
            r_q   <= red;
            g_q   <= green;
            b_q   <= blue;
            a_q   <= alpha;
            ci_q  <= clear_index;
            if (func == ppdb_pkg::FN_CLEAR) begin
              state <= S_CLEAR;
            end else if (depth_z <= 24'(near_depth)) begin
              res_status <= ppdb_pkg::ST_NEAR;
              res_index  <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_XSTART;
            end
          end
        end
        S_CLEAR: begin
          res_status <= ppdb_pkg::ST_CLEARED;
          res_index  <= ci_q;
          state      <= S_DONE;
        end
        S_XSTART: state <= S_XWAIT;
        S_XWAIT: begin
          if (div_res.done) begin
            qx    <= div_res.quo;
            bigx  <= div_res.big;
            nzx   <= div_res.rem_nz;
            state <= S_YSTART;
          end
        end
        S_YSTART: state <= S_YWAIT;
        S_YWAIT: begin
          if (div_res.done) begin
            qy    <= div_res.quo;
            bigy  <= div_res.big;
            nzy   <= div_res.rem_nz;
            state <= S_PROJ;
          end
        end
        S_PROJ: begin
          if (off_c) begin
            res_status <= ppdb_pkg::ST_OFF;
            res_index  <= '0;
            state      <= S_DONE;
          end else begin
            sx_u  <= sx_c[CW-2:0];
            sy_u  <= sy_c[CW-2:0];
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          addr      <= ppdb_pkg::ADDR_W'(idx_full);
          res_index <= 12'(idx_full);
          state     <= S_READ;
        end
        S_READ: state <= S_TEST;
        S_TEST: begin
          if (depth_test_on && !(depth_rd > z_q)) begin
            res_status <= ppdb_pkg::ST_DEPTH;
            state      <= S_DONE;
          end else begin
            chan  <= CH_RED;
            state <= S_BLEND;
          end
        end
        S_BLEND: begin
          unique case (chan)
            CH_RED: begin
              nr   <= blend_c;
              chan <= CH_GREEN;
            end
            CH_GREEN: begin
              ng   <= blend_c;
              chan <= CH_BLUE;
            end
            CH_BLUE: begin
              nb    <= blend_c;
              state <= S_WRITE;
            end
            default: chan <= CH_RED;
          endcase
        end
        S_WRITE: begin
          res_status <= ppdb_pkg::ST_WRITTEN;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            pixel_index <= res_index;
            out_red     <= (res_status == ppdb_pkg::ST_WRITTEN) ? nr : '0;
            out_green   <= (res_status == ppdb_pkg::ST_WRITTEN) ? ng : '0;
            out_blue    <= (res_status == ppdb_pkg::ST_WRITTEN) ? nb : '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_unwritten = out_valid && (status != ppdb_pkg::ST_WRITTEN);
  assign out_rgb_zero  = ({out_red, out_green, out_blue} == '0);
  assign out_rejected  = out_valid &&
                         ((status == ppdb_pkg::ST_NEAR) || (status == ppdb_pkg::ST_OFF));
  assign div_waiting   = (state == S_XWAIT) || (state == S_YWAIT);
  assign dep_allowed   = depth_test_on || (state == S_CLEAR);

  `PPDB_ASSERT_IMPLIES(a_colour_only_written, out_unwritten, out_rgb_zero, "colour with no write")
  `PPDB_ASSERT_IMPLIES(a_reject_no_index, out_rejected, pixel_index == '0, "index on a reject")
  `PPDB_ASSERT_IMPLIES(a_div_done_waited, div_res.done, div_waiting, "divider done outside a wait")
  `PPDB_ASSERT_IMPLIES(a_depth_write_ok, st_wr.dep_en, dep_allowed, "depth write with test off")
  `PPDB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "word taken while busy")

endmodule

`default_nettype wire

// ----- test/projected_pixel_depth_blend_tb.sv -----
// Self-checking testbench for projected_pixel_depth_blend: random and directed plot and clear
// words against a mirror of the colour and depth stores. Needs ppdb_pkg and the RTL only.
`default_nettype none

module projected_pixel_depth_blend_tb;

  typedef struct packed {
    ppdb_pkg::func_t    func;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [23:0]        depth_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [11:0]        clear_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_result_t;

  class pixel_store_mirror;
    logic [ppdb_pkg::COLOUR_W-1:0] colour_mem [ppdb_pkg::STORE_SIZE];
    logic [ppdb_pkg::DEPTH_W-1:0]  depth_mem  [ppdb_pkg::STORE_SIZE];
    logic [6:0]          width_reg;
    logic [6:0]          height_reg;
    logic [15:0]         fov_reg;
    logic [15:0]         near_reg;
    logic                ztest_reg;
    pixel_result_t       expected_pixels[$];
    int                  errors;
    int                  results_seen;
    int                  last_touched;

    function new();
      foreach (colour_mem[i]) begin
        colour_mem[i] = '0;
        depth_mem[i]  = ppdb_pkg::FAR_DEPTH;
      end
      width_reg    = 7'd64;
      height_reg   = 7'd64;
      fov_reg      = 16'd256;
      near_reg     = 16'd26;
      ztest_reg    = 1'b1;
      errors       = 0;
      results_seen = 0;
      last_touched = 0;
    endfunction

    function void set_reg(ppdb_pkg::cfg_reg_t idx, logic [15:0] d);
      case (idx)
        ppdb_pkg::REG_WIDTH:      width_reg  = d[6:0];
        ppdb_pkg::REG_HEIGHT:     height_reg = d[6:0];
        ppdb_pkg::REG_FOV:        fov_reg    = d;
        ppdb_pkg::REG_NEAR:       near_reg   = d;
        ppdb_pkg::REG_DEPTH_TEST: ztest_reg  = d[0];
        default: ;
      endcase
    endfunction

    // half +/- mag/den, truncated toward zero
    function longint screen_pos(longint half, longint unsigned mag, bit neg,
                                longint unsigned den);
      longint unsigned q, r;
      longint          t;
      q = mag / den;
      r = mag % den;
      if (!neg) return half + longint'(q);
      t = half - longint'(q);
      if (r != 0 && t >= 1) return t - 1;
      return t;
    endfunction

    function logic [7:0] mix(logic [7:0] c, logic [7:0] b, logic [7:0] a);
      int unsigned s;
      s = c * a + b * (255 - a);
      return 8'(s / 255);
    endfunction

    function void accept_word(in_word_t w);
      pixel_result_t       r;
      longint              x, y, sx, sy, wd, ht;
      longint unsigned     z, den, mx, my;
      int unsigned         idx;
      logic [ppdb_pkg::COLOUR_W-1:0] old;
      r = '0;
      if (w.func == ppdb_pkg::FN_CLEAR) begin
        if (w.clear_index < ppdb_pkg::STORE_SIZE) begin
          colour_mem[w.clear_index] = '0;
          depth_mem[w.clear_index]  = ppdb_pkg::FAR_DEPTH;
        end
        r.status      = ppdb_pkg::ST_CLEARED;
        r.pixel_index = w.clear_index;
      end else if (w.depth_z <= near_reg) begin
        r.status = ppdb_pkg::ST_NEAR;
      end else begin
        wd  = (width_reg > ppdb_pkg::MAX_WIDTH) ? ppdb_pkg::MAX_WIDTH : width_reg;
        ht  = (height_reg > ppdb_pkg::MAX_HEIGHT) ? ppdb_pkg::MAX_HEIGHT : height_reg;
        x   = longint'($signed(w.pos_x));
        y   = longint'($signed(w.pos_y));
        z   = w.depth_z;
        den = z << 8;
        mx  = longint'((x < 0) ? -x : x) * fov_reg;
        my  = longint'((y < 0) ? -y : y) * fov_reg;
        sx  = screen_pos(wd / 2, mx, x < 0, den);
        sy  = screen_pos(ht / 2, my, y > 0, den);
        if (sx < 0 || sy < 0 || sx >= wd || sy >= ht) begin
          r.status = ppdb_pkg::ST_OFF;
        end else begin
          idx           = int'(sy * wd + sx);
          r.pixel_index = idx[11:0];
          last_touched  = idx;
          if (ztest_reg && depth_mem[idx] <= z) begin
            r.status = ppdb_pkg::ST_DEPTH;
          end else begin
            if (ztest_reg) depth_mem[idx] = z[23:0];
            old     = colour_mem[idx];
            r.red   = mix(w.red, old[23:16], w.alpha);
            r.green = mix(w.green, old[15:8], w.alpha);
            r.blue  = mix(w.blue, old[7:0], w.alpha);
            colour_mem[idx] = {r.red, r.green, r.blue};
            r.status = ppdb_pkg::ST_WRITTEN;
          end
        end
      end
      expected_pixels.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 30) $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare_result(pixel_result_t got);
      pixel_result_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("unexpected word st=%0d idx=%0d", got.status, got.pixel_index));
        return;
      end
      want = expected_pixels.pop_front();
      if (got.status !== want.status || got.pixel_index !== want.pixel_index ||
          got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
        report($sformatf("word %0d got st=%0d idx=%0d rgb=%h%h%h want st=%0d idx=%0d rgb=%h%h%h",
                         results_seen, got.status, got.pixel_index, got.red, got.green,
                         got.blue, want.status, want.pixel_index, want.red, want.green,
                         want.blue));
      results_seen++;
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               func;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic [23:0]        depth_z;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         alpha;
  logic [11:0]        clear_index;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         status;
  logic [11:0]        pixel_index;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  pixel_store_mirror mirror = new();

  int          send_idle  = 0;
  int          recv_stall = 0;
  int          hold_left  = 0;
  logic [23:0] last_x     = '0;
  logic [23:0] last_y     = '0;

  projected_pixel_depth_blend dut (.*);

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // receiver: random stalls plus an optional long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready)
      mirror.compare_result(pixel_result_t'{status, pixel_index, out_red, out_green,
                                            out_blue});
  end

  function automatic in_word_t plot_word(longint x, longint y, longint unsigned z,
                                         logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                         logic [7:0] a);
    in_word_t w;
    w.func        = ppdb_pkg::FN_PLOT;
    w.pos_x       = 24'(x);
    w.pos_y       = 24'(y);
    w.depth_z     = 24'(z);
    w.red         = r;
    w.green       = g;
    w.blue        = b;
    w.alpha       = a;
    w.clear_index = 12'($urandom);
    return w;
  endfunction

  function automatic in_word_t clear_word(logic [11:0] ci);
    in_word_t w;
    w             = in_word_t'({$urandom, $urandom, $urandom, $urandom});
    w.func        = ppdb_pkg::FN_CLEAR;
    w.clear_index = ci;
    return w;
  endfunction

  // world coordinate that lands near or just outside the surface at depth zl
  function automatic logic [23:0] aim(logic [6:0] dim, longint unsigned zl);
    int unsigned     d;
    longint unsigned mag;
    d = (dim > ppdb_pkg::MAX_DIM) ? ppdb_pkg::MAX_DIM : dim;
    if (mirror.fov_reg == 0)
      mag = $urandom_range(24'h7FFFFF);
    else
      mag = longint'($urandom_range((d / 2 + 2) * 256)) * zl / mirror.fov_reg;
    if (mag > 24'h7FFFFF) mag = 24'h7FFFFF;
    return $urandom_range(1) ? 24'(-longint'(mag)) : 24'(mag);
  endfunction

  function automatic in_word_t make_word();
    in_word_t        w;
    int unsigned     pick;
    longint unsigned zl;
    w      = in_word_t'({$urandom, $urandom, $urandom, $urandom});
    w.func = ppdb_pkg::FN_PLOT;
    case ($urandom_range(7))
      0: w.alpha = 8'hFF;
      1: w.alpha = 8'h00;
      default: ;
    endcase
    pick = $urandom_range(99);
    if (pick < 10) begin
      w.func = ppdb_pkg::FN_CLEAR;
      if (pick < 5) w.clear_index = 12'(mirror.last_touched);
    end else if (pick < 18) begin
      // raw noise
    end else if (pick < 22) begin
      w.depth_z = 24'($urandom_range(mirror.near_reg));
    end else begin
      zl = mirror.near_reg + 1 + $urandom_range(2047);
      if (pick < 30) zl = $urandom_range(24'hFFFFFF, mirror.near_reg + 1);
      w.depth_z = 24'(zl);
      if (pick < 45) begin
        w.pos_x = last_x;
        w.pos_y = last_y;
      end else begin
        w.pos_x = aim(mirror.width_reg, zl);
        w.pos_y = aim(mirror.height_reg, zl);
      end
      last_x = w.pos_x;
      last_y = w.pos_y;
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    func        <= w.func;
    pos_x       <= w.pos_x;
    pos_y       <= w.pos_y;
    depth_z     <= w.depth_z;
    red         <= w.red;
    green       <= w.green;
    blue        <= w.blue;
    alpha       <= w.alpha;
    clear_index <= w.clear_index;
    do @(posedge clk); while (!in_ready);
    mirror.accept_word(w);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (mirror.expected_pixels.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic write_reg(ppdb_pkg::cfg_reg_t idx, logic [15:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    mirror.set_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // unused upper data bits are randomized
  task automatic configure(logic [6:0] w, logic [6:0] h, logic [15:0] fov,
                           logic [15:0] near, logic zt);
    write_reg(ppdb_pkg::REG_WIDTH, {9'($urandom), w});
    write_reg(ppdb_pkg::REG_HEIGHT, {9'($urandom), h});
    write_reg(ppdb_pkg::REG_FOV, fov);
    write_reg(ppdb_pkg::REG_NEAR, near);
    write_reg(ppdb_pkg::REG_DEPTH_TEST, {15'($urandom), zt});
  endtask

  task automatic run_phase(int n, int s_idle, int r_stall);
    send_idle  = s_idle;
    recv_stall = r_stall;
    repeat (n) send_word(make_word());
    drain();
  endtask

  initial begin
    #1600000;
    $display("** projected_pixel_depth_blend: FAILED **");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    func        = ppdb_pkg::FN_PLOT;
    pos_x       = '0;
    pos_y       = '0;
    depth_z     = '0;
    red         = '0;
    green       = '0;
    blue        = '0;
    alpha       = '0;
    clear_index = '0;
    cfg_valid   = 1'b0;
    cfg_index   = ppdb_pkg::REG_WIDTH;
    cfg_data    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    configure(7'd64, 7'd64, 16'd256, 16'd26, 1'b1);

    // directed: near limits, centre writes, depth compare, blends, edges, clears
    send_word(plot_word(0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(plot_word(0, 0, 26, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(plot_word(0, 0, 27, 8'h12, 8'h34, 8'h56, 8'hFF));
    send_word(plot_word(0, 0, 256, 8'hFF, 8'h00, 8'hFF, 8'hFF));
    send_word(clear_word(12'(32 * 64 + 32)));
    send_word(plot_word(0, 0, 256, 8'hFF, 8'h80, 8'h00, 8'hFF));
    send_word(plot_word(0, 0, 256, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_word(plot_word(0, 0, 200, 8'h0A, 8'h14, 8'h1E, 8'h00));
    send_word(plot_word(0, 0, 100, 8'h00, 8'hFF, 8'hFF, 8'h80));
    send_word(plot_word(-1, -1, 256, 8'hC0, 8'h40, 8'h20, 8'hFF));
    send_word(plot_word(1, 1, 256, 8'h01, 8'h02, 8'h03, 8'h7F));
    send_word(plot_word(31 * 256, 32 * 256, 256, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(plot_word(32 * 256, 0, 256, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(plot_word(0, -32 * 256, 256, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(plot_word(-32 * 256, -31 * 256, 256, 8'h55, 8'hAA, 8'h55, 8'hFF));
    send_word(plot_word(-32 * 256 - 1, 0, 256, 8'h33, 8'h66, 8'h99, 8'hFF));
    send_word(plot_word(8388607, 0, 256, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(plot_word(-8388608, 0, 256, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(plot_word(0, 8388607, 256, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(plot_word(0, -8388608, 256, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(plot_word(8388607, -8388608, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(clear_word(12'd0));
    send_word(clear_word(12'd4095));
    drain();

    run_phase(100, 0, 0);

    configure(7'd1, 7'd1, 16'd0, 16'd0, 1'b0);
    run_phase(60, 74, 0);

    // above the maximum: saturates
    configure(7'd127, 7'd127, 16'hFFFF, 16'hFFFF, 1'b1);
    run_phase(100, 0, 74);

    configure(7'd40, 7'd23, 16'd384, 16'd100, 1'b1);
    hold_left = 400;
    run_phase(120, 18, 18);

    configure(7'd0, 7'd50, 16'd256, 16'd26, 1'b1);
    run_phase(30, 0, 0);

    configure(7'd50, 7'd0, 16'd512, 16'd0, 1'b0);
    run_phase(30, 0, 0);

    configure(7'($urandom_range(64, 1)), 7'($urandom_range(64, 1)),
              16'($urandom_range(1024, 64)), 16'($urandom_range(300)),
              1'($urandom_range(1)));
    run_phase(150, 74, 0);

    send_idle  = 0;
    recv_stall = 0;
    repeat (60) @(posedge clk);
    if (mirror.expected_pixels.size() != 0)
      mirror.report($sformatf("%0d results never arrived", mirror.expected_pixels.size()));
    if (mirror.errors == 0)
      $display("** projected_pixel_depth_blend: PASSED **");
    else
      $display("** projected_pixel_depth_blend: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
